// ===== rtl/assert_macros.svh =====
// Assertion helpers for the frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define RFD_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define RFD_ASSERT(lbl, clk, rst_n, prop)

`define RFD_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/rfd_pkg.sv =====
`timescale 1ns / 1ps

package rfd_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int COUNT_W      = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 8'd3;

    localparam int OFS_MAGIC   = 0;
    localparam int OFS_VERSION = 2;
    localparam int OFS_HSIZE   = 3;
    localparam int OFS_KIND    = 4;
    localparam int OFS_FLAGS   = 6;
    localparam int OFS_RECORD  = 8;
    localparam int OFS_SESSION = 12;
    localparam int OFS_STAMP   = 16;
    localparam int OFS_RATE    = 24;
    localparam int OFS_BODY    = 28;
    localparam int OFS_RSVD    = 30;

    typedef logic [HEADER_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic        frame_ok;
        logic [15:0] record_kind;
        logic [15:0] record_flags;
        logic [31:0] record_number;
        logic [31:0] session_number;
        logic [63:0] tick_stamp;
        logic [31:0] tick_rate;
        logic [15:0] body_length;
    } t_out;

    typedef struct packed {
        t_hdr               hdr;
        logic [COUNT_W-1:0] total;
        logic               overflow;
    } t_frame;

    typedef struct packed {
        logic [15:0] magic_word;
        logic [7:0]  version_byte;
        logic [15:0] payload_limit;
        logic        big_endian;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    function automatic logic [63:0] get_field(input t_hdr hdr, input int pos,
                                              input int len, input logic be);
        logic [63:0]          acc;
        logic [HDR_IDX_W-1:0] idx;
        acc = '0;
        idx = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                idx = be ? HDR_IDX_W'(pos + i) : HDR_IDX_W'(pos + len - 1 - i);
                acc = {acc[55:0], hdr[idx]};
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/rfd_front.sv =====
`timescale 1ns / 1ps

module rfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  rfd_pkg::t_in    i_data,
    output logic            o_push,
    output rfd_pkg::t_frame o_frame
);

    logic [rfd_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_ovf, n_ovf;
    rfd_pkg::t_hdr               r_hdr, n_hdr;

    always_comb begin
        n_hdr = r_hdr;
        if (r_count < rfd_pkg::COUNT_W'(rfd_pkg::HEADER_BYTES)) begin
            n_hdr[r_count[rfd_pkg::HDR_IDX_W-1:0]] = i_data.data_byte;
        end
        n_ovf   = r_ovf | (r_count == rfd_pkg::COUNT_MAX);
        n_count = (r_count == rfd_pkg::COUNT_MAX) ? r_count
                                                   : r_count + 1'b1;
    end

    assign o_push         = i_accept & i_data.end_of_message;
    assign o_frame.hdr      = n_hdr;
    assign o_frame.total    = n_count;
    assign o_frame.overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_data.end_of_message) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

// ===== rtl/rfd_queue.sv =====
`timescale 1ns / 1ps

module rfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfd_pkg::t_frame  i_frame,
    input  logic             i_pop,
    output rfd_pkg::t_frame  o_frame,
    output rfd_pkg::t_q_stat o_stat
);

    rfd_pkg::t_frame                 r_mem [rfd_pkg::QUEUE_DEPTH];
    logic [rfd_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [rfd_pkg::QUEUE_CNT_W-1:0] r_count;

    localparam logic [rfd_pkg::QUEUE_PTR_W-1:0] LastPtr =
        rfd_pkg::QUEUE_PTR_W'(rfd_pkg::QUEUE_DEPTH - 1);

    assign o_frame      = r_mem[r_rd_ptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == rfd_pkg::QUEUE_CNT_W'(rfd_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// ===== rtl/rfd_back.sv =====
`timescale 1ns / 1ps

module rfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfd_pkg::t_cfg    i_cfg,
    input  rfd_pkg::t_frame  i_frame,
    input  rfd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output rfd_pkg::t_out    o_out_data
);

    logic          r_valid;
    rfd_pkg::t_out r_out, n_out;
    logic [15:0]   w_magic, w_body, w_rsvd;
    logic          w_ok;

    always_comb begin
        w_magic = 16'(rfd_pkg::get_field(i_frame.hdr, rfd_pkg::OFS_MAGIC, 2,
                                         i_cfg.big_endian));
        w_body  = 16'(rfd_pkg::get_field(i_frame.hdr, rfd_pkg::OFS_BODY, 2,
                                         i_cfg.big_endian));
        w_rsvd  = 16'(rfd_pkg::get_field(i_frame.hdr, rfd_pkg::OFS_RSVD, 2,
                                         i_cfg.big_endian));
        w_ok = !i_frame.overflow
            && (i_frame.total >= rfd_pkg::COUNT_W'(rfd_pkg::HEADER_BYTES))
            && (w_magic == i_cfg.magic_word)
            && (i_frame.hdr[rfd_pkg::OFS_VERSION] == i_cfg.version_byte)
            && (i_frame.hdr[rfd_pkg::OFS_HSIZE] == 8'(rfd_pkg::HEADER_BYTES))
            && (w_body <= i_cfg.payload_limit)
            && (w_rsvd == 16'd0)
            && (i_frame.total == rfd_pkg::COUNT_W'(rfd_pkg::HEADER_BYTES)
                                 + rfd_pkg::COUNT_W'(w_body));
        n_out = '0;
        if (w_ok) begin
            n_out.frame_ok       = 1'b1;
            n_out.record_kind    = 16'(rfd_pkg::get_field(i_frame.hdr,
                                       rfd_pkg::OFS_KIND, 2, i_cfg.big_endian));
            n_out.record_flags   = 16'(rfd_pkg::get_field(i_frame.hdr,
                                       rfd_pkg::OFS_FLAGS, 2, i_cfg.big_endian));
            n_out.record_number  = 32'(rfd_pkg::get_field(i_frame.hdr,
                                       rfd_pkg::OFS_RECORD, 4, i_cfg.big_endian));
            n_out.session_number = 32'(rfd_pkg::get_field(i_frame.hdr,
                                       rfd_pkg::OFS_SESSION, 4, i_cfg.big_endian));
            n_out.tick_stamp     = rfd_pkg::get_field(i_frame.hdr,
                                       rfd_pkg::OFS_STAMP, 8, i_cfg.big_endian);
            n_out.tick_rate      = 32'(rfd_pkg::get_field(i_frame.hdr,
                                       rfd_pkg::OFS_RATE, 4, i_cfg.big_endian));
            n_out.body_length    = w_body;
        end
    end

    assign o_pop       = i_q_stat.valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/record_frame_decoder.sv =====
`timescale 1ns / 1ps
// A frame is queued at the edge that accepts its final byte, then popped into the output register (result valid).
// Throughput: one byte per cycle unless stalled; a result may follow every cycle (2-deep frame queue).
// Input stalls only while the frame queue is full; config writes always ready.
// Reset (synchronous, active low) clears counts, queue and output valid, and resets config (limit to 0xFFFF);
// header bytes stay undefined until written.
`include "assert_macros.svh"

module record_frame_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  rfd_pkg::t_in                     i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output rfd_pkg::t_out                    o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    rfd_pkg::t_cfg    r_cfg;
    rfd_pkg::t_frame  w_push_frame, w_head_frame;
    rfd_pkg::t_q_stat w_q_stat;
    logic             w_accept, w_push, w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_stat.full;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word    <= '0;
            r_cfg.version_byte  <= '0;
            r_cfg.payload_limit <= 16'hFFFF;
            r_cfg.big_endian    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rfd_pkg::CFG_MAGIC:      r_cfg.magic_word    <= i_cfg_data;
                rfd_pkg::CFG_VERSION:    r_cfg.version_byte  <= i_cfg_data[7:0];
                rfd_pkg::CFG_LIMIT:      r_cfg.payload_limit <= i_cfg_data;
                rfd_pkg::CFG_BIG_ENDIAN: r_cfg.big_endian    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_data  (i_in_data),
        .o_push  (w_push),
        .o_frame (w_push_frame)
    );

    rfd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_frame(w_push_frame),
        .i_pop  (w_pop),
        .o_frame(w_head_frame),
        .o_stat (w_q_stat)
    );

    rfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_frame    (w_head_frame),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

    `RFD_NEVER(a_push_when_full, i_clk, i_rst_n, w_push && w_q_stat.full)
    `RFD_NEVER(a_pop_when_empty, i_clk, i_rst_n, w_pop && !w_q_stat.valid)
    `RFD_ASSERT(a_fail_zeroed, i_clk, i_rst_n,
                (o_out_valid && !o_out_data.frame_ok) |->
                (o_out_data.body_length == 16'd0 && o_out_data.tick_stamp == 64'd0))
    `RFD_ASSERT(a_pop_fills_out, i_clk, i_rst_n, w_pop |=> o_out_valid)

endmodule
